// ----- rtl/core/rqpr_pkg.sv -----
// Shared types and constants for the ring queue with prefix reversal.
// Holds the command, status and controller state codes and the packing widths.
// No dependencies; the top level, the checker and the testbench import this package.
package rqpr_pkg;

   // Widths fixed by the stream packing of both channels.
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;
   localparam int TDATA_W = 40;
   localparam int TUSER_W = 2;

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_POP     = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_REVERSE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_COUNT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SWAP_WA,
      ST_SWAP_WB
   } state_type;

endpackage

// ----- rtl/core/rqpr_store.sv -----
// Entry store of the ring queue: one write port and two read ports.
// Read data is registered, so it appears in the cycle after the address while rd_en is high.
// Depends on nothing outside this file.
module rqpr_store #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ----- rtl/core/ring_queue_prefix_reverse_top.sv -----
// Top level of the ring queue with prefix reversal.
// Uses rqpr_pkg for codes and widths and rqpr_store for the entry memory.
// The checker in rqpr_checker.sv binds to this module.

// A circular FIFO of signed words that holds up to STORE_DEPTH-1 entries and
// takes one command per request word: push, pop, peek the head, or reverse the
// order of the first k entries. Every request produces exactly one response
// word carrying the word read, a status and the occupancy after the command.
// Push, rejected commands and reversals of zero or one entry answer straight
// from idle. Pop and peek wait in ST_POP_WAIT, because the entry store has a
// registered read. A reversal of k entries makes floor(k/2) swaps: each swap
// reads both entries together and then writes them back one after the other
// through the store's single write port. A new request is taken only while the
// controller is idle and the response register is empty or being drained.
// The store needs no clearing after reset; only entries that were pushed are
// ever read.
module ring_queue_prefix_reverse_top #(
   parameter int STORE_DEPTH = 128,
   parameter int WORD_WIDTH  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: push_value[31:0], reverse_count[38:32], zero pad.
   input  logic [rqpr_pkg::TDATA_W-1:0]   req_tdata,
   // Fields from bit 0: mode[1:0].
   input  logic [rqpr_pkg::TUSER_W-1:0]   req_tuser,
   // Response channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: read_value[31:0], occupancy[38:32], zero pad.
   output logic [rqpr_pkg::TDATA_W-1:0]   rsp_tdata,
   // Fields from bit 0: status[1:0].
   output logic [rqpr_pkg::TUSER_W-1:0]   rsp_tuser
);

   import rqpr_pkg::*;

   localparam int IW = $clog2(STORE_DEPTH);
   // Comparison width wide enough for both the count and reverse_count.
   localparam int CW = (IW > COUNT_W) ? IW : COUNT_W;
   localparam logic [IW-1:0]   LAST_IDX   = IW'(STORE_DEPTH - 1);
   localparam logic [IW:0]     DEPTH_WIDE = (IW + 1)'(STORE_DEPTH);

   // Controller state.
   state_type state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] count_ff, count_in;

   // Swap walk: low and high positions and pairs still to swap.
   logic [IW-1:0]        lo_ff, lo_in;
   logic [IW-1:0]        hi_ff, hi_in;
   logic [COUNT_W-2:0]   pairs_ff, pairs_in;
   logic [WORD_WIDTH-1:0] tmp_ff, tmp_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_occ_ff, rsp_occ_in;

   // Store ports.
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IW-1:0]         rd_addr_a, rd_addr_b;
   logic [WORD_WIDTH-1:0] rd_data_a, rd_data_b;

   // Request decode.
   logic                  req_fire;
   cmd_type               req_mode;
   logic [VALUE_W-1:0]    req_value;
   logic [COUNT_W-1:0]    req_count;
   logic [WORD_WIDTH-1:0] push_word;
   logic [VALUE_W-1:0]    head_value;
   logic                  is_full, is_empty, count_too_big;
   logic [IW:0]           hi_sum;
   logic [IW-1:0]         hi_start;
   logic [IW-1:0]         lo_next, hi_next;
   logic [CW-1:0]         occ_wide;

   assign req_mode  = cmd_type'(req_tuser);
   assign req_value = req_tdata[VALUE_W-1:0];
   assign req_count = req_tdata[VALUE_W+COUNT_W-1:VALUE_W];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // Stored words keep WORD_WIDTH bits; read words narrower than 32 are sign extended to 32.
   generate
      if (WORD_WIDTH <= VALUE_W) begin : g_push_narrow
         assign push_word = req_value[WORD_WIDTH-1:0];
      end else begin : g_push_wide
         assign push_word = {{(WORD_WIDTH - VALUE_W){1'b0}}, req_value};
      end
      if (WORD_WIDTH >= VALUE_W) begin : g_read_wide
         assign head_value = rd_data_a[VALUE_W-1:0];
      end else begin : g_read_narrow
         assign head_value = {{(VALUE_W - WORD_WIDTH){rd_data_a[WORD_WIDTH-1]}}, rd_data_a};
      end
   endgenerate

   assign is_full       = (count_ff == LAST_IDX);
   assign is_empty      = (count_ff == '0);
   assign count_too_big = CW'(req_count) > CW'(count_ff);

   // Last position of the reversed prefix. Only used when k <= occupancy,
   // so k fits the index width and one subtraction of the depth suffices.
   assign hi_sum   = (IW + 1)'(head_ff) + (IW + 1)'(req_count) - (IW + 1)'(1);
   assign hi_start = (hi_sum >= DEPTH_WIDE) ? IW'(hi_sum - DEPTH_WIDE) : IW'(hi_sum);

   assign lo_next = (lo_ff == LAST_IDX) ? '0 : lo_ff + IW'(1);
   assign hi_next = (hi_ff == '0) ? LAST_IDX : hi_ff - IW'(1);

   assign occ_wide = CW'(count_in);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_mode == CMD_POP || req_mode == CMD_PEEK) && !is_empty) begin
                  state_in = ST_POP_WAIT;
               end else if (req_mode == CMD_REVERSE && !count_too_big
                            && req_count[COUNT_W-1:1] != '0) begin
                  state_in = ST_SWAP_WA;
               end
            end
         end
         ST_POP_WAIT: state_in = ST_IDLE;
         ST_SWAP_WA:  state_in = ST_SWAP_WB;
         ST_SWAP_WB: begin
            state_in = (pairs_ff == (COUNT_W - 1)'(1)) ? ST_IDLE : ST_SWAP_WA;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, store control and response.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      pairs_in      = pairs_ff;
      tmp_in        = tmp_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;
      wr_data       = push_word;
      rd_en         = 1'b0;
      rd_addr_a     = head_ff;
      rd_addr_b     = hi_start;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_value_in  = '0;
               rsp_status_in = STAT_OK;
               case (req_mode) inside
                  CMD_PUSH: begin
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + IW'(1);
                        count_in = count_ff + IW'(1);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        // The response is formed when the read data returns.
                        rd_en = 1'b1;
                        if (req_mode == CMD_POP) begin
                           head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + IW'(1);
                           count_in = count_ff - IW'(1);
                        end
                     end
                  end
                  default: begin
                     if (count_too_big) begin
                        rsp_status_in = STAT_COUNT;
                        rsp_valid_in  = 1'b1;
                     end else if (req_count[COUNT_W-1:1] == '0) begin
                        // Zero or one entry: nothing to swap.
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        lo_in    = head_ff;
                        hi_in    = hi_start;
                        pairs_in = req_count[COUNT_W-1:1];
                     end
                  end
               endcase
               rsp_occ_in = occ_wide[COUNT_W-1:0];
            end
         end
         ST_POP_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = head_value;
            rsp_status_in = STAT_OK;
            rsp_occ_in    = occ_wide[COUNT_W-1:0];
         end
         ST_SWAP_WA: begin
            // Low slot takes the high word; the low word waits in tmp.
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data_b;
            tmp_in  = rd_data_a;
         end
         ST_SWAP_WB: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = tmp_ff;
            lo_in    = lo_next;
            hi_in    = hi_next;
            pairs_in = pairs_ff - (COUNT_W - 1)'(1);
            // Fetch the next pair now; it never overlaps the slot being written.
            if (pairs_ff == (COUNT_W - 1)'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STAT_OK;
               rsp_occ_in    = occ_wide[COUNT_W-1:0];
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = lo_next;
               rd_addr_b = hi_next;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      pairs_ff      <= pairs_in;
      tmp_ff        <= tmp_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   rqpr_store #(
      .DEPTH  (STORE_DEPTH),
      .WIDTH  (WORD_WIDTH),
      .ADDR_W (IW)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - VALUE_W - COUNT_W){1'b0}}, rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- rtl/core/rqpr_checker.sv -----
// Port-level checker for the ring queue with prefix reversal.
// Uses rqpr_pkg for status codes; bound to ring_queue_prefix_reverse_top below.
module rqpr_checker #(
   parameter int STORE_DEPTH = 128
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [rqpr_pkg::TDATA_W-1:0] req_tdata,
   input logic [rqpr_pkg::TUSER_W-1:0] req_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [rqpr_pkg::TDATA_W-1:0] rsp_tdata,
   input logic [rqpr_pkg::TUSER_W-1:0] rsp_tuser
);

   import rqpr_pkg::*;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready && (req_tdata == req_tdata)
                     && (req_tuser == req_tuser);

   // A request is only taken when its response has a free slot.
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!rsp_tvalid || rsp_tready))
      else $error("request accepted while the response register is blocked");

   // Every rejected command reports a zero word.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_OK) |-> (rsp_tdata[VALUE_W-1:0] == '0))
      else $error("error response carries a nonzero word");

   // Occupancy never reaches the store depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[VALUE_W+COUNT_W-1:VALUE_W]) < STORE_DEPTH))
      else $error("reported occupancy exceeds the queue capacity");

   // A stalled response holds its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind ring_queue_prefix_reverse_top rqpr_checker #(
   .STORE_DEPTH (STORE_DEPTH)
) u_rqpr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- test/testbench.sv -----
// Self-checking testbench for ring_queue_prefix_reverse_top.
// Depends on rqpr_pkg for the command and status codes and on the RTL top level.
// A queue-filled driver, a clocked monitor and an in-bench queue predictor.
`timescale 1ns / 1ps

module testbench;
   import rqpr_pkg::*;

   localparam int CYCLE_NS      = 12;
   localparam int HOLD_LIMIT    = 4000;
   localparam int PHASE_WORDS   = 400;
   localparam int MAX_HELD      = 127;

   typedef struct {
      cmd_type     mode;
      logic [31:0] value;
      logic [6:0]  count;
      int          phase;
      bit          drain;
   } command_type;

   typedef struct {
      logic [31:0] read_value;
      status_type  status;
      logic [6:0]  occupancy;
   } reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata = '0;
   logic [TUSER_W-1:0]  req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;
   logic [TUSER_W-1:0]  rsp_tuser;

   command_type command_backlog[$];
   reply_type   expected_replies[$];
   command_type command_on_bus;

   // Shadow of the queue: entries, head and tail wrap at 128 like the block.
   logic [31:0] shadow_store [0:127];
   logic [6:0]  shadow_head = '0;
   logic [6:0]  shadow_tail = '0;

   int tx_idle_by_phase [4] = '{0, 67, 0, 15};
   int rx_stall_by_phase[4] = '{0, 0, 67, 15};
   int rx_stall_pct = 0;
   int gen_held = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int replies_checked = 0;
   int mode_seen  [4] = '{0, 0, 0, 0};
   int status_seen[4] = '{0, 0, 0, 0};
   int peak_held = 0;
   int longest_reverse = 0;

   ring_queue_prefix_reverse_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #(CYCLE_NS / 2) clock = ~clock;
   end

   // Applies one command to the shadow queue and returns the reply it must produce.
   function automatic reply_type queue_model_step(command_type c);
      reply_type   r;
      logic [6:0]  held;
      logic [6:0]  a;
      logic [6:0]  b;
      logic [31:0] swap_tmp;
      r.read_value = '0;
      r.status     = STAT_OK;
      held = shadow_tail - shadow_head;
      case (c.mode) inside
         CMD_PUSH: begin
            if (held == 7'(MAX_HELD)) begin
               r.status = STAT_FULL;
            end else begin
               shadow_store[shadow_tail] = c.value;
               shadow_tail = shadow_tail + 7'd1;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (held == 7'd0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.read_value = shadow_store[shadow_head];
               if (c.mode == CMD_POP) shadow_head = shadow_head + 7'd1;
            end
         end
         default: begin
            if (c.count > held) begin
               r.status = STAT_COUNT;
            end else begin
               // Swap mirrored pairs inside the first k entries; the rest stay put.
               for (int i = 0; i < int'(c.count) / 2; i++) begin
                  a = shadow_head + 7'(i);
                  b = shadow_head + c.count - 7'd1 - 7'(i);
                  swap_tmp = shadow_store[a];
                  shadow_store[a] = shadow_store[b];
                  shadow_store[b] = swap_tmp;
               end
            end
         end
      endcase
      r.occupancy = shadow_tail - shadow_head;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
   endtask

   // Appends one command to the backlog and keeps a count of entries for shaping.
   task automatic queue_command(cmd_type mode, logic [31:0] value, int count, int phase,
                                bit drain);
      command_type c;
      c.mode  = mode;
      c.value = value;
      c.count = 7'(count);
      c.phase = phase;
      c.drain = drain;
      command_backlog.push_back(c);
      case (mode)
         CMD_PUSH: if (gen_held < MAX_HELD) gen_held++;
         CMD_POP:  if (gen_held > 0) gen_held--;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] random_word();
      logic [31:0] corner [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
      if ($urandom_range(99) < 10) return corner[$urandom_range(4)];
      return $urandom;
   endfunction

   function automatic int random_reverse_count();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(gen_held);
      if (roll < 85) return gen_held;
      return $urandom_range(MAX_HELD);
   endfunction

   // Directed opening, then four phases of random traffic with their own idle and stall
   // rates. Each phase opens by filling the queue to the brim so the full and whole-queue
   // reversal cases are reached every time, then wanders through fill, drain and
   // mixed bursts.
   task automatic build_stimulus();
      int phase_start;
      int regime;
      int roll;
      bit drain;
      queue_command(CMD_POP, 32'h0, 0, 0, 1'b0);
      queue_command(CMD_PEEK, 32'h0, 0, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 1, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 0, 0, 1'b0);
      queue_command(CMD_PUSH, 32'h7fff_ffff, 0, 0, 1'b0);
      queue_command(CMD_PUSH, 32'h8000_0000, 0, 0, 1'b0);
      queue_command(CMD_PUSH, 32'h0, 0, 0, 1'b0);
      queue_command(CMD_PUSH, 32'hffff_ffff, 0, 0, 1'b0);
      queue_command(CMD_PUSH, 32'h1, 0, 0, 1'b0);
      queue_command(CMD_PEEK, 32'h0, 0, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 0, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 1, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 2, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 5, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 6, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 127, 0, 1'b0);
      queue_command(CMD_REVERSE, 32'h0, 4, 0, 1'b0);
      queue_command(CMD_PEEK, 32'h0, 0, 0, 1'b0);
      repeat (6) queue_command(CMD_POP, 32'h0, 0, 0, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         phase_start = command_backlog.size();
         drain = 1'b1;
         while (gen_held < MAX_HELD) begin
            queue_command(CMD_PUSH, random_word(), 0, phase, drain);
            drain = 1'b0;
         end
         queue_command(CMD_PUSH, random_word(), 0, phase, 1'b0);
         queue_command(CMD_PUSH, random_word(), 0, phase, 1'b0);
         queue_command(CMD_REVERSE, 32'h0, MAX_HELD, phase, 1'b0);
         queue_command(CMD_PEEK, 32'h0, 0, phase, 1'b0);
         queue_command(CMD_REVERSE, 32'h0, random_reverse_count(), phase, 1'b0);
         while (command_backlog.size() - phase_start < PHASE_WORDS) begin
            regime = $urandom_range(2);
            repeat ($urandom_range(60, 20)) begin
               roll  = $urandom_range(99);
               drain = ($urandom_range(99) == 0);
               // Regime 0 fills, regime 1 drains, regime 2 keeps the level roughly steady.
               if (roll < (regime == 0 ? 60 : regime == 1 ? 20 : 40))
                  queue_command(CMD_PUSH, random_word(), 0, phase, drain);
               else if (roll < (regime == 0 ? 75 : regime == 1 ? 65 : 70))
                  queue_command(CMD_POP, 32'h0, 0, phase, drain);
               else if (roll < (regime == 0 ? 82 : regime == 1 ? 75 : 80))
                  queue_command(CMD_PEEK, 32'h0, 0, phase, drain);
               else
                  queue_command(CMD_REVERSE, 32'h0, random_reverse_count(), phase, drain);
            end
         end
      end
   endtask

   // Driver: predicts each accepted word and presents the next one from the backlog.
   // A word marked for draining waits until every outstanding reply has come back.
   always @(posedge clock) begin
      reply_type   r;
      command_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            r = queue_model_step(command_on_bus);
            expected_replies.push_back(r);
            mode_seen[command_on_bus.mode]++;
            status_seen[r.status]++;
            if (int'(r.occupancy) > peak_held) peak_held = r.occupancy;
            if (command_on_bus.mode == CMD_REVERSE && r.status == STAT_OK &&
                int'(command_on_bus.count) > longest_reverse)
               longest_reverse = command_on_bus.count;
         end
         if (!req_tvalid || req_tready) begin
            if (command_backlog.size() != 0 &&
                !(command_backlog[0].drain && expected_replies.size() != 0) &&
                $urandom_range(99) >= tx_idle_by_phase[command_backlog[0].phase]) begin
               nxt = command_backlog.pop_front();
               command_on_bus <= nxt;
               rx_stall_pct   <= rx_stall_by_phase[nxt.phase];
               req_tvalid     <= 1'b1;
               req_tdata      <= {1'b0, nxt.count, nxt.value};
               req_tuser      <= nxt.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted reply against the oldest prediction.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected reply", rsp_tdata[31:0], 32'h0);
            end else begin
               want = expected_replies.pop_front();
               replies_checked++;
               if (rsp_tdata[31:0] !== want.read_value)
                  report_mismatch("read_value", rsp_tdata[31:0], want.read_value);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[38:32] !== want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_tdata[38:32]), 32'(want.occupancy));
            end
         end
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Watchdog: a long reversal plus a stalled reply stays far below the limit.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= HOLD_LIMIT) begin
            $display("%0t no word moved for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (command_backlog.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(posedge clock);
      // Let any stray reply surface before the final verdict.
      repeat (20) @(posedge clock);
      if (expected_replies.size() != 0)
         report_mismatch("missing replies", 32'(expected_replies.size()), 32'h0);
      $display("Checked %0d replies: %0d push, %0d pop, %0d peek, %0d reverse commands.",
               replies_checked, mode_seen[CMD_PUSH], mode_seen[CMD_POP],
               mode_seen[CMD_PEEK], mode_seen[CMD_REVERSE]);
      $write("Dropped pushes %0d, empty reads %0d, oversized reversals %0d; ",
             status_seen[STAT_FULL], status_seen[STAT_EMPTY], status_seen[STAT_COUNT]);
      $display("peak fill %0d, longest reversal %0d.", peak_held, longest_reverse);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
